// File: rtl/bcfm_pkg.sv
// Package for the battery cell fault monitor: item kinds, register indexes,
// reset values of the limits and the constants of the sense-bit mapping.
// No dependencies; imported by battery_cell_fault_monitor.
`timescale 1ns / 1ps

package bcfm_pkg;

    typedef enum logic [1:0] {
        KIND_CELL  = 2'd0,
        KIND_THERM = 2'd1,
        KIND_END_V = 2'd2,
        KIND_END_T = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_OV_LIMIT   = 2'd0,
        CFG_SOFT_LIMIT = 2'd1,
        CFG_UV_LIMIT   = 2'd2,
        CFG_THERM_FRAC = 2'd3
    } cfg_index_t;

    localparam int DEFAULT_NUM_MONITORS      = 8;
    localparam int DEFAULT_CELLS_PER_MONITOR = 10;

    localparam int LIMIT_W = 16;
    localparam int COUNT_W = 8;
    localparam int MASK_W  = 12;
    localparam int SENSE_W = 4;
    localparam int MON_W   = 3;
    localparam int CH_W    = 4;

    localparam logic [LIMIT_W-1:0] OV_LIMIT_RESET   = 16'd36000;
    localparam logic [LIMIT_W-1:0] SOFT_LIMIT_RESET = 16'd36200;
    localparam logic [LIMIT_W-1:0] UV_LIMIT_RESET   = 16'd22000;
    localparam logic [LIMIT_W-1:0] THERM_FRAC_RESET = 16'd3807;

    localparam logic [31:0] THERM_REF_SCALE = 32'd1000;

    // Channels from this one upwards skip one sense position.
    localparam logic [CH_W-1:0] SENSE_GAP_CH = 4'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    // Bit positions in the fault flag register.
    localparam int FLAG_OV   = 0;
    localparam int FLAG_SOFT = 1;
    localparam int FLAG_UV   = 2;
    localparam int FLAG_OT   = 3;

    typedef struct packed {
        logic [7:0]         read_faults;
        logic               relays_closed;
        logic [LIMIT_W-1:0] reference;
        logic [LIMIT_W-1:0] sample;
        logic [CH_W-1:0]    channel;
        logic [MON_W-1:0]   monitor_index;
        kind_t              kind;
    } item_t;

endpackage

// File: rtl/battery_cell_fault_monitor.sv
// Battery cell fault monitor top level: input register, fault and balancing
// logic with its state, and a result register. Depends on bcfm_pkg.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid/s_tready    tuser kind, tdata sample item
//  m_       out        m_tvalid/m_tready    tdata flags, sense, mask, count
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per clock cycle is sustained while m_tready is high; a request that
// is taken loads the input register, and its result is then loaded into the
// result register, from which it is offered on the m_ channel.
// The state is read and updated in the single stage between the two registers.
// Reset is synchronous and active low; it restores the limits to their defaults
// and clears counts, flags and all balancing masks at once.
// While m_tready is low the result holds and s_tready drops once the input
// register is full. cfg_ready is always high.
`timescale 1ns / 1ps

module battery_cell_fault_monitor
    import bcfm_pkg::*;
#(
    parameter int NUM_MONITORS      = DEFAULT_NUM_MONITORS,
    parameter int CELLS_PER_MONITOR = DEFAULT_CELLS_PER_MONITOR
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] monitor_index, [6:3] channel, [22:7] sample, [38:23] reference,
    // [39] relays_closed, [47:40] read_faults
    input  logic [47:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] over-voltage flag, [1] soft over-voltage flag, [2] under-voltage flag,
    // [3] over_temperature, [7:4] sense_bit, [19:8] discharge_mask,
    // [27:20] sweep_errors, [31:28] zero
    output logic [31:0] m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int MON_IDX_W = (NUM_MONITORS > 1) ? $clog2(NUM_MONITORS) : 1;

    logic [LIMIT_W-1:0] ov_limit_reg;
    logic [LIMIT_W-1:0] soft_limit_reg;
    logic [LIMIT_W-1:0] uv_limit_reg;
    logic [LIMIT_W-1:0] therm_frac_reg;

    item_t              item_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic [31:0]        out_data_next;

    logic [COUNT_W-1:0] v_count_reg, v_count_next;
    logic [COUNT_W-1:0] t_count_reg, t_count_next;
    logic [3:0]         flags_reg, flags_next;
    logic [MASK_W-1:0]  mask_reg [NUM_MONITORS];

    logic               advance;
    logic               mon_ok;
    logic               cell_ok;
    logic [MON_IDX_W-1:0] mon_idx;
    logic [MASK_W-1:0]  old_mask;
    logic [MASK_W-1:0]  new_mask;
    logic [MASK_W-1:0]  cell_bit;
    logic               mask_wr;
    logic [SENSE_W-1:0] sense_cell;
    logic [SENSE_W-1:0] sense_out;
    logic [MASK_W-1:0]  mask_out;
    logic [COUNT_W-1:0] errs_out;
    logic               ov_hit, soft_hit, uv_hit, ot_hit;
    logic [31:0]        therm_lhs, therm_rhs;
    logic [COUNT_W:0]   v_cell_sum, t_sum, v_end_sum, t_end_sum;
    logic [COUNT_W-1:0] v_cell_sat, t_sat, v_end_sat, t_end_sat;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_limit_reg   <= OV_LIMIT_RESET;
            soft_limit_reg <= SOFT_LIMIT_RESET;
            uv_limit_reg   <= UV_LIMIT_RESET;
            therm_frac_reg <= THERM_FRAC_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OV_LIMIT:   ov_limit_reg   <= cfg_data;
                CFG_SOFT_LIMIT: soft_limit_reg <= cfg_data;
                CFG_UV_LIMIT:   uv_limit_reg   <= cfg_data;
                CFG_THERM_FRAC: therm_frac_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.kind          <= kind_t'(s_tuser);
            item_reg.monitor_index <= s_tdata[2:0];
            item_reg.channel       <= s_tdata[6:3];
            item_reg.sample        <= s_tdata[22:7];
            item_reg.reference     <= s_tdata[38:23];
            item_reg.relays_closed <= s_tdata[39];
            item_reg.read_faults   <= s_tdata[47:40];
        end
    end

    assign mon_ok  = int'(item_reg.monitor_index) < NUM_MONITORS;
    assign cell_ok = mon_ok && (int'(item_reg.channel) < CELLS_PER_MONITOR);
    assign mon_idx = MON_IDX_W'(item_reg.monitor_index);
    assign old_mask = mon_ok ? mask_reg[mon_idx] : '0;

    assign sense_cell = (item_reg.channel < SENSE_GAP_CH) ? item_reg.channel
                                                          : item_reg.channel + 4'd1;
    assign cell_bit   = MASK_W'(1) << sense_cell;

    assign ov_hit   = item_reg.sample > ov_limit_reg;
    assign soft_hit = item_reg.sample > soft_limit_reg;
    assign uv_hit   = item_reg.sample < uv_limit_reg;

    assign therm_lhs = {16'd0, item_reg.sample} * {16'd0, therm_frac_reg};
    assign therm_rhs = {16'd0, item_reg.reference} * THERM_REF_SCALE;
    assign ot_hit    = therm_lhs < therm_rhs;

    assign v_cell_sum = {1'b0, v_count_reg} + {{COUNT_W{1'b0}}, ov_hit}
                                            + {{COUNT_W{1'b0}}, uv_hit};
    assign v_cell_sat = v_cell_sum[COUNT_W] ? COUNT_MAX : v_cell_sum[COUNT_W-1:0];
    assign t_sum      = {1'b0, t_count_reg} + {{COUNT_W{1'b0}}, ot_hit};
    assign t_sat      = t_sum[COUNT_W] ? COUNT_MAX : t_sum[COUNT_W-1:0];
    assign v_end_sum  = {1'b0, v_count_reg} + {1'b0, item_reg.read_faults};
    assign v_end_sat  = v_end_sum[COUNT_W] ? COUNT_MAX : v_end_sum[COUNT_W-1:0];
    assign t_end_sum  = {1'b0, t_count_reg} + {1'b0, item_reg.read_faults};
    assign t_end_sat  = t_end_sum[COUNT_W] ? COUNT_MAX : t_end_sum[COUNT_W-1:0];

    always_comb begin
        flags_next   = flags_reg;
        v_count_next = v_count_reg;
        t_count_next = t_count_reg;
        mask_wr      = 1'b0;
        new_mask     = old_mask;
        sense_out    = '0;
        errs_out     = '0;
        unique case (item_reg.kind)
            KIND_CELL: begin
                if (cell_ok) begin
                    flags_next[FLAG_OV]   = flags_reg[FLAG_OV] | ov_hit;
                    flags_next[FLAG_SOFT] = flags_reg[FLAG_SOFT] | soft_hit;
                    flags_next[FLAG_UV]   = flags_reg[FLAG_UV] | uv_hit;
                    v_count_next = v_cell_sat;
                    mask_wr      = 1'b1;
                    new_mask     = (old_mask & ~cell_bit)
                                 | ((soft_hit && item_reg.relays_closed) ? cell_bit : '0);
                    sense_out    = sense_cell;
                end
                errs_out = v_count_next;
            end
            KIND_THERM: begin
                flags_next[FLAG_OT] = flags_reg[FLAG_OT] | ot_hit;
                t_count_next = t_sat;
                errs_out     = t_sat;
            end
            KIND_END_V: begin
                if (v_end_sat == '0) begin
                    flags_next[FLAG_OV] = 1'b0;
                    flags_next[FLAG_UV] = 1'b0;
                end
                v_count_next = '0;
                errs_out     = v_end_sat;
            end
            KIND_END_T: begin
                if (t_end_sat == '0) begin
                    flags_next[FLAG_OT] = 1'b0;
                end
                t_count_next = '0;
                errs_out     = t_end_sat;
            end
            default: ;
        endcase
        mask_out = new_mask;
        out_data_next = {4'd0, errs_out, mask_out, sense_out, flags_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_count_reg <= '0;
            t_count_reg <= '0;
            flags_reg   <= '0;
            for (int i = 0; i < NUM_MONITORS; i++) begin
                mask_reg[i] <= '0;
            end
        end else if (advance) begin
            v_count_reg <= v_count_next;
            t_count_reg <= t_count_next;
            flags_reg   <= flags_next;
            if (mask_wr) begin
                mask_reg[mon_idx] <= new_mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // The soft over-voltage flag is only ever cleared by reset.
    a_soft_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(flags_reg[FLAG_SOFT]))
        else $error("soft over-voltage flag cleared outside reset");

    // An end of voltage sweep restarts the voltage error count.
    a_v_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_reg.kind == KIND_END_V) |=> (v_count_reg == '0))
        else $error("voltage error count not restarted");

    // Sense positions five and eleven are never used.
    a_sense_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[7:4] != 4'd5 && out_data_reg[7:4] <= 4'd10))
        else $error("sense bit outside the mapped positions");

    // Balancing bits only ever sit at mapped sense positions.
    a_mask_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[13] == 1'b0 && out_data_reg[19] == 1'b0))
        else $error("balancing bit set at an unused position");

endmodule
